[design/rms_voice_activity_detector_core_assert.svh]
// Assertion macros for the voice activity detector.
// Each macro takes a label, an antecedent and a consequent, sampled on clk
// and disabled while rst_n is low.
`ifndef RMS_VOICE_ACTIVITY_DETECTOR_CORE_ASSERT_SVH
`define RMS_VOICE_ACTIVITY_DETECTOR_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define RVAD_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rvad assertion failed");
`define RVAD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rvad assertion failed");
`else
`define RVAD_ASSERT_SAME(lbl, ante, cons)
`define RVAD_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[design/rvad_pkg.sv]
package rvad_pkg;

  localparam int MaxFrameDefault = 1024;
  localparam int RootSteps       = 16;

  // register indexes on the configuration port
  localparam logic [1:0] RegStartThr  = 2'd0;
  localparam logic [1:0] RegStopThr   = 2'd1;
  localparam logic [1:0] RegTimeoutMs = 2'd2;

  localparam logic [15:0] StartThrReset  = 16'd500;
  localparam logic [15:0] StopThrReset   = 16'd300;
  localparam logic [15:0] TimeoutMsReset = 16'd800;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               frame_end;
    logic [31:0]        time_ms;
  } in_t;

  typedef struct packed {
    logic        speech;
    logic [15:0] energy;
  } out_t;

  typedef struct packed {
    logic load;       // capture the accepted transfer
    logic square;     // register the sample square
    logic acc;        // add the square into the frame sum
    logic prep;       // load the divider and clear the frame
    logic div_step;   // one quotient bit
    logic root_init;  // load the root unit from the quotient
    logic root_step;  // one root bit
    logic decide;     // run the hysteresis and post the result
  } cmd_t;

  typedef struct packed {
    logic last;       // captured sample closes the frame
    logic out_free;   // result register can take a new result
  } sts_t;

endpackage

[design/rvad_ctrl.sv]
module rvad_ctrl #(
  parameter int SumW = 31 + $clog2(rvad_pkg::MaxFrameDefault)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  rvad_pkg::sts_t sts,
  output rvad_pkg::cmd_t cmd
);

  localparam int StepW = $clog2(SumW + 1);

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StSquare = 3'd1;
  localparam logic [2:0] StAcc    = 3'd2;
  localparam logic [2:0] StPrep   = 3'd3;
  localparam logic [2:0] StDiv    = 3'd4;
  localparam logic [2:0] StRinit  = 3'd5;
  localparam logic [2:0] StRoot   = 3'd6;
  localparam logic [2:0] StDecide = 3'd7;

  logic [2:0]       state_r, state_nxt;
  logic [StepW-1:0] step_r, step_nxt;

  assign in_ready = (state_r == StIdle);

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    unique case (state_r)
      StIdle: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = StSquare;
        end
      end
      StSquare: begin
        cmd.square = 1'b1;
        state_nxt  = StAcc;
      end
      StAcc: begin
        cmd.acc   = 1'b1;
        state_nxt = sts.last ? StPrep : StIdle;
      end
      StPrep: begin
        cmd.prep  = 1'b1;
        step_nxt  = '0;
        state_nxt = StDiv;
      end
      StDiv: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + 1'b1;
        if (step_r == StepW'(SumW - 1)) begin
          state_nxt = StRinit;
        end
      end
      StRinit: begin
        cmd.root_init = 1'b1;
        step_nxt      = '0;
        state_nxt     = StRoot;
      end
      StRoot: begin
        cmd.root_step = 1'b1;
        step_nxt      = step_r + 1'b1;
        if (step_r == StepW'(rvad_pkg::RootSteps - 1)) begin
          state_nxt = StDecide;
        end
      end
      StDecide: begin
        // hold until the previous result has left
        if (sts.out_free) begin
          cmd.decide = 1'b1;
          state_nxt  = StIdle;
        end
      end
      default: state_nxt = StIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= StIdle;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt;
  end

endmodule

[design/rvad_dp.sv]
module rvad_dp #(
  parameter int MaxFrame = rvad_pkg::MaxFrameDefault,
  parameter int SumW     = 31 + $clog2(MaxFrame)
) (
  input  logic           clk,
  input  logic           rst_n,
  input  rvad_pkg::cmd_t cmd,
  output rvad_pkg::sts_t sts,
  input  rvad_pkg::in_t  in_data,
  input  logic           cfg_wr_en,
  input  logic [1:0]     cfg_index,
  input  logic [15:0]    cfg_data,
  input  logic           out_ready,
  output logic           out_valid,
  output rvad_pkg::out_t out_data
);

  localparam int CntW = $clog2(MaxFrame + 1);

  logic [15:0] start_thr_r, stop_thr_r, timeout_r;

  logic signed [15:0] smp_r;
  logic               last_r;
  logic [31:0]        time_r;
  logic [30:0]        sq_r;
  logic signed [31:0] prod;

  logic [SumW-1:0] sum_r;
  logic [CntW-1:0] cnt_r;

  logic [CntW-1:0] div_r;
  logic [SumW-1:0] quo_r;
  logic [CntW-1:0] rem_r;
  logic [CntW:0]   rem_sh;
  logic            rem_ge;

  logic [31:0] rad_r;
  logic [15:0] root_r;
  logic [17:0] srem_r;
  logic [17:0] srem_sh;
  logic [17:0] trial;
  logic        srem_ge;

  logic        in_speech_r, in_speech_nxt;
  logic [31:0] sil_r, sil_nxt;
  logic        speech_nxt;
  logic [31:0] quiet_ms;

  logic        out_valid_r;
  rvad_pkg::out_t out_r;

  assign prod = 32'(smp_r) * 32'(smp_r);

  // restoring divide, one quotient bit a cycle
  assign rem_sh = {rem_r, quo_r[SumW-1]};
  assign rem_ge = (rem_sh >= {1'b0, div_r});

  // digit-by-digit root, one bit a cycle
  assign srem_sh = {srem_r[15:0], rad_r[31:30]};
  assign trial   = {root_r, 2'b01};
  assign srem_ge = (srem_sh >= trial);

  assign quiet_ms = time_r - sil_r;

  always_comb begin
    in_speech_nxt = in_speech_r;
    sil_nxt       = sil_r;
    speech_nxt    = 1'b1;
    if (!in_speech_r) begin
      if (root_r >= start_thr_r) begin
        in_speech_nxt = 1'b1;
        sil_nxt       = '0;
      end else begin
        speech_nxt = 1'b0;
      end
    end else if (root_r < stop_thr_r) begin
      // zero marks an unstarted silence timer
      if (sil_r == '0) begin
        sil_nxt = time_r;
      end else if (quiet_ms >= {16'd0, timeout_r}) begin
        in_speech_nxt = 1'b0;
        sil_nxt       = '0;
        speech_nxt    = 1'b0;
      end
    end else begin
      sil_nxt = '0;
    end
  end

  assign sts.last     = last_r;
  assign sts.out_free = !out_valid_r || out_ready;
  assign out_valid    = out_valid_r;
  assign out_data     = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_thr_r <= rvad_pkg::StartThrReset;
      stop_thr_r  <= rvad_pkg::StopThrReset;
      timeout_r   <= rvad_pkg::TimeoutMsReset;
      sum_r       <= '0;
      cnt_r       <= '0;
      in_speech_r <= 1'b0;
      sil_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          rvad_pkg::RegStartThr:  start_thr_r <= cfg_data;
          rvad_pkg::RegStopThr:   stop_thr_r  <= cfg_data;
          rvad_pkg::RegTimeoutMs: timeout_r   <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.acc && (cnt_r < CntW'(MaxFrame))) begin
        sum_r <= sum_r + SumW'(sq_r);
        cnt_r <= cnt_r + 1'b1;
      end
      if (cmd.prep) begin
        sum_r <= '0;
        cnt_r <= '0;
      end
      if (cmd.decide) begin
        in_speech_r <= in_speech_nxt;
        sil_r       <= sil_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      smp_r  <= in_data.sample;
      last_r <= in_data.frame_end;
      time_r <= in_data.time_ms;
    end
    if (cmd.square) begin
      sq_r <= prod[30:0];
    end
    if (cmd.prep) begin
      div_r <= cnt_r;
      quo_r <= sum_r;
      rem_r <= '0;
    end
    if (cmd.div_step) begin
      quo_r <= {quo_r[SumW-2:0], rem_ge};
      rem_r <= rem_ge ? CntW'(rem_sh - {1'b0, div_r}) : rem_sh[CntW-1:0];
    end
    if (cmd.root_init) begin
      // the mean square never exceeds 2^30
      rad_r  <= 32'(quo_r);
      root_r <= '0;
      srem_r <= '0;
    end
    if (cmd.root_step) begin
      rad_r  <= {rad_r[29:0], 2'b00};
      root_r <= {root_r[14:0], srem_ge};
      srem_r <= srem_ge ? (srem_sh - trial) : srem_sh;
    end
    if (cmd.decide) begin
      out_r.speech <= speech_nxt;
      out_r.energy <= root_r;
    end
  end

endmodule

[design/rms_voice_activity_detector_core.sv]
// RMS voice activity detector. Each input transfer carries one signed 16-bit
// sample, a frame_end flag and a millisecond timestamp. Squares are summed over
// the frame; up to MAX_FRAME samples count, and later samples of an overlong
// frame (including its frame_end sample) add nothing. On the frame_end sample
// the block divides the sum by the sample count, takes the floor square root,
// and runs a speech/silence hysteresis: speech starts at energy >= start
// threshold; during speech, energy below the stop threshold stamps a silence
// timer from time_ms (a stamp of zero means the timer is not running), and
// speech ends once time_ms minus the stamp reaches the timeout. One result
// transfer (speech flag, energy) leaves per frame. A sample that does not end a
// frame passes through capture, square and accumulate; a frame_end sample also
// goes through prepare, divide, root init, root and decide. The frame sum is
// SUM_W = 31 + clog2(MAX_FRAME) bits wide; the divider produces one quotient
// bit per cycle and the root unit one root bit per cycle. The decide step
// waits while a previous result is held in the output register. Configuration
// writes take effect on the next clock and must come only while the block is idle.
`include "rms_voice_activity_detector_core_assert.svh"

module rms_voice_activity_detector_core #(
  parameter int MAX_FRAME = rvad_pkg::MaxFrameDefault
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  rvad_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output rvad_pkg::out_t out_data,
  input  logic           cfg_wr_en,
  input  logic [1:0]     cfg_index,
  input  logic [15:0]    cfg_data
);

  // sum of squares: each square is at most 2^30
  localparam int SumW = 31 + $clog2(MAX_FRAME);

  rvad_pkg::cmd_t cmd;
  rvad_pkg::sts_t sts;

  // sequence capture, accumulate, divide, root and decide
  rvad_ctrl #(
    .SumW(SumW)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  // hold the frame sums, the iterative units, the hysteresis state
  // and the result register
  rvad_dp #(
    .MaxFrame(MAX_FRAME),
    .SumW    (SumW)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .in_data  (in_data),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .out_ready(out_ready),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  // a new result appears only after the block stopped taking samples
  `RVAD_ASSERT_SAME(a_result_while_busy, $rose(out_valid), !$past(in_ready))
  // an accepted transfer always keeps the block busy for the next cycle
  `RVAD_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  // the root of the mean square of 16-bit samples never exceeds 32768
  `RVAD_ASSERT_SAME(a_energy_range, out_valid, out_data.energy <= 16'd32768)

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps

module tb;
  import rvad_pkg::*;

  localparam int MAX_FRAME     = MaxFrameDefault;
  localparam int IDLE_LIMIT    = 4000;   // cycles without any transfer before giving up
  localparam int SETTLE_CYCLES = 80;     // covers one frame_end pass plus margin
  localparam int PHASES        = 7;
  localparam int PHASE_ITEMS   = 28;
  localparam int DIR_ROWS      = 27;
  localparam int MISS_SHOWN    = 10;
  localparam logic [1:0] RegUnused = 2'd3;

  // One row of the directed table: either a register write or one sample.
  // Rows flagged as typed carry their result inline; the rest go through
  // the energy predictor.
  typedef struct packed {
    logic        is_cfg;
    logic [1:0]  reg_idx;
    logic [15:0] reg_val;
    logic [15:0] smp;
    logic        last;
    logic [31:0] t_ms;
    logic        typed;
    logic        exp_speech;
    logic [15:0] exp_energy;
  } step_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;
  logic        cfg_wr_en;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  // Predictor state: thresholds, hysteresis and the running frame sums.
  logic [15:0]     thr_start;
  logic [15:0]     thr_stop;
  logic [15:0]     quiet_limit_ms;
  bit              talk_active;
  logic [31:0]     quiet_since_ms;
  longint unsigned energy_acc;
  int              acc_count;

  out_t frame_verdicts_q[$];
  int   miss_count;
  int   idle_cycles;
  bit   gaps_on;

  logic [15:0] ph_start [PHASES] = '{16'd500, 16'd100, 16'd32768, 16'd2000,
                                     16'd65535, 16'd0, 16'd3000};
  logic [15:0] ph_stop  [PHASES] = '{16'd300, 16'd50, 16'd32768, 16'd1500,
                                     16'd0, 16'd0, 16'd2999};
  logic [15:0] ph_tmo   [PHASES] = '{16'd800, 16'd0, 16'd65535, 16'd300,
                                     16'd1, 16'd65535, 16'd50};

  step_row_t dir_tab [DIR_ROWS];

  rms_voice_activity_detector_core #(
    .MAX_FRAME(MAX_FRAME)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Floor square root by bisection; the mean square never exceeds 2^30.
  function automatic logic [16:0] floor_root(input logic [63:0] v);
    logic [16:0] lo;
    logic [16:0] hi;
    logic [16:0] mid;
    lo = '0;
    hi = 17'd32769;
    while (hi - lo > 17'd1) begin
      mid = (lo + hi) >> 1;
      if (64'(mid) * 64'(mid) <= v) lo = mid;
      else hi = mid;
    end
    return lo;
  endfunction

  // Advance the predictor by one accepted sample. Return 1 when the sample
  // closes a frame, with the speech verdict and energy in verdict.
  function automatic bit vad_step(input in_t it, output out_t verdict);
    logic signed [15:0] s16;
    longint             sv;
    logic [16:0]        level;
    logic [31:0]        elapsed;
    s16 = it.sample;
    sv = s16;
    verdict = '0;
    // Drop samples past the frame cap, including a late frame_end sample.
    if (acc_count < MAX_FRAME) begin
      energy_acc = energy_acc + 64'(sv * sv);
      acc_count++;
    end
    if (!it.frame_end) return 1'b0;

    level = floor_root(energy_acc / 64'(acc_count));
    energy_acc = 0;
    acc_count = 0;

    if (!talk_active) begin
      if (level >= {1'b0, thr_start}) begin
        talk_active = 1'b1;
        quiet_since_ms = '0;
      end
    end else if (level < {1'b0, thr_stop}) begin
      // A zero stamp means the silence timer has not started yet.
      if (quiet_since_ms == '0) begin
        quiet_since_ms = it.time_ms;
      end else begin
        elapsed = it.time_ms - quiet_since_ms;
        if (elapsed >= 32'(quiet_limit_ms)) begin
          talk_active = 1'b0;
          quiet_since_ms = '0;
        end
      end
    end else begin
      quiet_since_ms = '0;
    end

    verdict.speech = talk_active;
    verdict.energy = level[15:0];
    return 1'b1;
  endfunction

  // Map a magnitude to a 16-bit sample, saturating at both ends.
  function automatic logic [15:0] signed_mag(input int mag, input bit neg);
    if (mag <= 0) return 16'h0000;
    if (mag >= 32768) return 16'h8000;
    return neg ? 16'(-mag) : 16'(mag);
  endfunction

  function automatic void log_miss(input string what, input int unsigned want_v,
                                   input int unsigned got_v);
    if (miss_count < MISS_SHOWN)
      $display("%0t mismatch: %s expected %0d got %0d", $realtime, what, want_v, got_v);
    miss_count++;
  endfunction

  // Hand one sample to the block: optionally hold valid low for a burst,
  // then raise valid and wait for the transfer.
  task automatic send_sample(input in_t it, input bit typed, input out_t typed_res);
    out_t verdict;
    bit   closes;
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 7)) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    closes = vad_step(it, verdict);
    if (closes) frame_verdicts_q.push_back(typed ? typed_res : verdict);
  endtask

  // Stop sending, let every pending frame come out, then give the block
  // time to finish any frame that cannot produce a result.
  task automatic drain_block();
    @(negedge clk);
    in_valid <= 1'b0;
    while (frame_verdicts_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      RegStartThr:  thr_start = val;
      RegStopThr:   thr_stop = val;
      RegTimeoutMs: quiet_limit_ms = val;
      default: ;  // unused index: block ignores it
    endcase
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Result side: stall out_ready in random bursts.
  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (gaps_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(0, 7)) @(negedge clk);
        @(negedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Compare each result transfer with the oldest pending verdict.
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (frame_verdicts_q.size() == 0) begin
        log_miss("result with nothing pending, energy", 0, out_data.energy);
      end else begin
        want = frame_verdicts_q.pop_front();
        if (out_data.speech !== want.speech)
          log_miss("speech", want.speech, out_data.speech);
        if (out_data.energy !== want.energy)
          log_miss("energy", want.energy, out_data.energy);
      end
    end
  end

  // Watchdog: count cycles with no transfer on any port.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[rms_voice_activity_detector_core] ERROR");
      $finish;
    end
  end

  initial begin
    step_row_t   row;
    in_t         it;
    out_t        typed_res;
    int          sent;
    int          len;
    int          mode;
    int          amp;
    int          jit;
    int          r;
    bit          neg;
    logic [31:0] clock_ms;

    // Directed walk: reset verdicts, full-scale samples, the zero stamp,
    // the exact timeout boundary, a two-sample frame, a wrapping timer,
    // timeout zero, thresholds at and past full scale, the unused index.
    dir_tab = '{
      {1'b0, RegStartThr, 16'd0, 16'h0000, 1'b1, 32'd100,        1'b1, 1'b0, 16'd0},
      {1'b0, RegStartThr, 16'd0, 16'h8000, 1'b1, 32'd200,        1'b1, 1'b1, 16'h8000},
      {1'b0, RegStartThr, 16'd0, 16'h7FFF, 1'b1, 32'd300,        1'b1, 1'b1, 16'h7FFF},
      {1'b0, RegStartThr, 16'd0, 16'h0000, 1'b1, 32'd0,          1'b0, 1'b0, 16'd0},
      {1'b0, RegStartThr, 16'd0, 16'h0000, 1'b1, 32'd1000,       1'b0, 1'b0, 16'd0},
      {1'b0, RegStartThr, 16'd0, 16'h0000, 1'b1, 32'd1799,       1'b0, 1'b0, 16'd0},
      {1'b0, RegStartThr, 16'd0, 16'h0000, 1'b1, 32'd1800,       1'b0, 1'b0, 16'd0},
      {1'b0, RegStartThr, 16'd0, 16'h0003, 1'b0, 32'hFFFF_FFFF,  1'b0, 1'b0, 16'd0},
      {1'b0, RegStartThr, 16'd0, 16'hFFFC, 1'b1, 32'd2000,       1'b0, 1'b0, 16'd0},
      {1'b0, RegStartThr, 16'd0, 16'd1000, 1'b1, 32'd2100,       1'b0, 1'b0, 16'd0},
      {1'b0, RegStartThr, 16'd0, 16'h0000, 1'b1, 32'hFFFF_FF00,  1'b0, 1'b0, 16'd0},
      {1'b0, RegStartThr, 16'd0, 16'h0000, 1'b1, 32'h0000_0100,  1'b0, 1'b0, 16'd0},
      {1'b0, RegStartThr, 16'd0, 16'h0000, 1'b1, 32'h0000_0220,  1'b0, 1'b0, 16'd0},
      {1'b1, RegTimeoutMs, 16'd0, 16'h0000, 1'b0, 32'd0,         1'b0, 1'b0, 16'd0},
      {1'b0, RegStartThr, 16'd0, 16'd1000, 1'b1, 32'd5,          1'b0, 1'b0, 16'd0},
      {1'b0, RegStartThr, 16'd0, 16'h0000, 1'b1, 32'd6,          1'b0, 1'b0, 16'd0},
      {1'b0, RegStartThr, 16'd0, 16'h0000, 1'b1, 32'd6,          1'b0, 1'b0, 16'd0},
      {1'b1, RegStartThr, 16'h8000, 16'h0000, 1'b0, 32'd0,       1'b0, 1'b0, 16'd0},
      {1'b0, RegStartThr, 16'd0, 16'h8000, 1'b1, 32'd10,         1'b0, 1'b0, 16'd0},
      {1'b1, RegStopThr,  16'h8001, 16'h0000, 1'b0, 32'd0,       1'b0, 1'b0, 16'd0},
      {1'b1, RegUnused,   16'hFFFF, 16'h0000, 1'b0, 32'd0,       1'b0, 1'b0, 16'd0},
      {1'b0, RegStartThr, 16'd0, 16'h8000, 1'b1, 32'd20,         1'b0, 1'b0, 16'd0},
      {1'b0, RegStartThr, 16'd0, 16'h8000, 1'b1, 32'd21,         1'b0, 1'b0, 16'd0},
      {1'b1, RegStartThr, 16'h0000, 16'h0000, 1'b0, 32'd0,       1'b0, 1'b0, 16'd0},
      {1'b1, RegStopThr,  16'h0000, 16'h0000, 1'b0, 32'd0,       1'b0, 1'b0, 16'd0},
      {1'b0, RegStartThr, 16'd0, 16'h0000, 1'b1, 32'd30,         1'b0, 1'b0, 16'd0},
      {1'b0, RegStartThr, 16'd0, 16'h0000, 1'b1, 32'd31,         1'b0, 1'b0, 16'd0}
    };

    // Drive every input to a known value before reset.
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_wr_en = 1'b0;
    cfg_index = RegStartThr;
    cfg_data  = '0;
    gaps_on   = 1'b1;
    miss_count  = 0;
    idle_cycles = 0;

    thr_start      = StartThrReset;
    thr_stop       = StopThrReset;
    quiet_limit_ms = TimeoutMsReset;
    talk_active    = 1'b0;
    quiet_since_ms = '0;
    energy_acc     = 0;
    acc_count      = 0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_ROWS; i++) begin
      row = dir_tab[i];
      if (row.is_cfg) begin
        drain_block();
        write_reg(row.reg_idx, row.reg_val);
      end else begin
        it.sample    = row.smp;
        it.frame_end = row.last;
        it.time_ms   = row.t_ms;
        typed_res.speech = row.exp_speech;
        typed_res.energy = row.exp_energy;
        send_sample(it, row.typed, typed_res);
      end
    end

    clock_ms = $urandom;
    for (int p = 0; p < PHASES; p++) begin
      // Reconfigure only once the block has gone quiet.
      drain_block();
      write_reg(RegStartThr, ph_start[p]);
      write_reg(RegStopThr, ph_stop[p]);
      write_reg(RegTimeoutMs, ph_tmo[p]);
      if (p == 4) write_reg(RegUnused, 16'h5A5A);
      gaps_on = (p != PHASES - 1);

      // Overlong frame: the kept part has one amplitude, the samples past
      // the cap (its frame_end sample among them) are full scale, so
      // counting a dropped sample shows up in energy.
      if (p == 0) begin
        for (int n = 0; n < MAX_FRAME + 6; n++) begin
          if (n < MAX_FRAME) it.sample = signed_mag(700, n[0]);
          else it.sample = n[0] ? 16'h8000 : 16'h7FFF;
          it.frame_end = (n == MAX_FRAME + 5);
          clock_ms += 32'd20;
          it.time_ms = clock_ms;
          send_sample(it, 1'b0, typed_res);
        end
      end

      sent = 0;
      while (sent < PHASE_ITEMS) begin
        len  = ($urandom_range(0, 39) == 0) ? $urandom_range(20, 64) : $urandom_range(1, 10);
        mode = $urandom_range(0, 4);
        amp  = $urandom_range(0, 40000);
        jit  = int'($urandom_range(0, 6)) - 3;
        for (int n = 0; n < len; n++) begin
          neg = 1'($urandom_range(0, 1));
          case (mode)
            0:       it.sample = signed_mag(int'(thr_start) + jit, neg);
            1:       it.sample = signed_mag(int'(thr_stop) + jit, neg);
            2:       it.sample = 16'($urandom);
            3:       it.sample = signed_mag($urandom_range(0, 40), neg);
            default: it.sample = signed_mag($urandom_range(0, amp), neg);
          endcase
          it.frame_end = (n == len - 1);
          if (it.frame_end) begin
            // Move the clock mostly forward in steps of up to half the timeout plus 40 ms,
            // with the odd zero stamp, wrap and long jump.
            r = $urandom_range(0, 29);
            if (r == 0) clock_ms = '0;
            else if (r == 1) clock_ms = $urandom;
            else if (r == 2) clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 500);
            else clock_ms += $urandom_range(0, int'(quiet_limit_ms) / 2 + 40);
            it.time_ms = clock_ms;
          end else begin
            it.time_ms = $urandom;
          end
          send_sample(it, 1'b0, typed_res);
          sent++;
        end
      end
    end

    drain_block();
    if (miss_count == 0) begin
      $display("[rms_voice_activity_detector_core] OK");
    end else begin
      $display("[rms_voice_activity_detector_core] ERROR");
    end
    $finish;
  end

endmodule
